// ----- hdl/soft_knee_audio_compressor_top_defines.svh -----
// assertion macros used by the checker file skac_checker.sv
`ifndef SOFT_KNEE_AUDIO_COMPRESSOR_TOP_DEFINES_SVH
`define SOFT_KNEE_AUDIO_COMPRESSOR_TOP_DEFINES_SVH

// same-cycle implication
`define SKAC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SKAC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/skac_pkg.sv -----
package skac_pkg;

  localparam int SAMPLE_BITS      = 24;
  localparam int STREAM_COUNT     = 2;
  localparam int SILENCE_FLOOR_DB = -120;

  localparam int FLOOR_INT = (SILENCE_FLOOR_DB * 256) < -32768 ? -32768
                                                               : (SILENCE_FLOOR_DB * 256);
  localparam logic signed [15:0] FLOOR_Q88 = 16'(FLOOR_INT);
  localparam logic [16:0]        NEG_FLOOR = 17'(-FLOOR_INT);

  localparam logic [18:0]        DB_PER_LOG2_Q16 = 19'd394566;
  localparam logic signed [15:0] LOG2_PER_DB_Q16 = 16'sd10885;
  localparam logic [15:0]        ATT_MAX         = 16'd40000;
  localparam logic [14:0]        RED_MAX         = 15'd32767;

  localparam int SQR_STEPS  = 16;
  localparam int DIV_STEPS  = 27;
  localparam int MANT_STEPS = 16;
  localparam int CNT_W      = 5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KNEE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAKEUP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BYPASS    = 3'd6;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_SHIFT, OP_SQR, OP_ATT, OP_LVL, OP_FLOOR,
    OP_ENVMUL, OP_ENVUPD, OP_OVER, OP_RZERO, OP_AMUL, OP_ASAT,
    OP_USQ, OP_USLOPE, OP_DIVINIT, OP_DIV, OP_DSAT, OP_GMUL, OP_GEXP,
    OP_MANT, OP_OUTC, OP_BYPASS, OP_FIN
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [CNT_W-1:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic bypass;
    logic peak_zero;
    logic norm_done;
    logic below;
    logic above;
    logic knee_zero;
  } sts_t;

  typedef logic [30:0] mant_tab_t [MANT_STEPS];

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] b;
    r = '0;
    x = v;
    for (int i = 0; i < 32; i++) begin
      b = 64'd1 << (62 - 2 * i);
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  // 2^(2^-(k+1)) in Q1.30 by repeated square roots
  function automatic mant_tab_t build_mant_tab();
    mant_tab_t   t;
    logic [63:0] w;
    w = isqrt64(64'd1 << 61);
    t[0] = w[30:0];
    for (int k = 1; k < MANT_STEPS; k++) begin
      w = isqrt64({w[33:0], 30'd0});
      t[k] = w[30:0];
    end
    return t;
  endfunction

  localparam mant_tab_t MANT_TAB = build_mant_tab();

endpackage

// ----- hdl/skac_ctrl.sv -----
module skac_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  skac_pkg::sts_t  sts_i,
  output skac_pkg::cmd_t  cmd_o
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_NORM    = 5'd1;
  localparam logic [4:0] S_SQR     = 5'd2;
  localparam logic [4:0] S_ATT     = 5'd3;
  localparam logic [4:0] S_LVL     = 5'd4;
  localparam logic [4:0] S_ENVMUL  = 5'd5;
  localparam logic [4:0] S_ENVUPD  = 5'd6;
  localparam logic [4:0] S_OVER    = 5'd7;
  localparam logic [4:0] S_RSEL    = 5'd8;
  localparam logic [4:0] S_AMUL    = 5'd9;
  localparam logic [4:0] S_ASAT    = 5'd10;
  localparam logic [4:0] S_USQ     = 5'd11;
  localparam logic [4:0] S_USLOPE  = 5'd12;
  localparam logic [4:0] S_DIVINIT = 5'd13;
  localparam logic [4:0] S_DIV     = 5'd14;
  localparam logic [4:0] S_DSAT    = 5'd15;
  localparam logic [4:0] S_GMUL    = 5'd16;
  localparam logic [4:0] S_GEXP    = 5'd17;
  localparam logic [4:0] S_MANT    = 5'd18;
  localparam logic [4:0] S_OUTC    = 5'd19;
  localparam logic [4:0] S_FIN     = 5'd20;

  localparam int CW = skac_pkg::CNT_W;

  logic [4:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.op    = skac_pkg::OP_NONE;
    cmd_o.cnt   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = skac_pkg::OP_LOAD;
          state_d  = S_NORM;
        end
      end
      S_NORM: begin
        if (sts_i.bypass) begin
          cmd_o.op = skac_pkg::OP_BYPASS;
          state_d  = S_FIN;
        end else if (sts_i.peak_zero) begin
          cmd_o.op = skac_pkg::OP_FLOOR;
          state_d  = S_ENVMUL;
        end else if (sts_i.norm_done) begin
          cnt_d   = '0;
          state_d = S_SQR;
        end else begin
          cmd_o.op = skac_pkg::OP_SHIFT;
        end
      end
      S_SQR: begin
        cmd_o.op = skac_pkg::OP_SQR;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CW'(skac_pkg::SQR_STEPS - 1)) state_d = S_ATT;
      end
      S_ATT: begin
        cmd_o.op = skac_pkg::OP_ATT;
        state_d  = S_LVL;
      end
      S_LVL: begin
        cmd_o.op = skac_pkg::OP_LVL;
        state_d  = S_ENVMUL;
      end
      S_ENVMUL: begin
        cmd_o.op = skac_pkg::OP_ENVMUL;
        state_d  = S_ENVUPD;
      end
      S_ENVUPD: begin
        cmd_o.op = skac_pkg::OP_ENVUPD;
        state_d  = S_OVER;
      end
      S_OVER: begin
        cmd_o.op = skac_pkg::OP_OVER;
        state_d  = S_RSEL;
      end
      S_RSEL: begin
        if (sts_i.below || (!sts_i.above && sts_i.knee_zero)) begin
          cmd_o.op = skac_pkg::OP_RZERO;
          state_d  = S_GMUL;
        end else if (sts_i.above) begin
          state_d = S_AMUL;
        end else begin
          state_d = S_USQ;
        end
      end
      S_AMUL: begin
        cmd_o.op = skac_pkg::OP_AMUL;
        state_d  = S_ASAT;
      end
      S_ASAT: begin
        cmd_o.op = skac_pkg::OP_ASAT;
        state_d  = S_GMUL;
      end
      S_USQ: begin
        cmd_o.op = skac_pkg::OP_USQ;
        state_d  = S_USLOPE;
      end
      S_USLOPE: begin
        cmd_o.op = skac_pkg::OP_USLOPE;
        state_d  = S_DIVINIT;
      end
      S_DIVINIT: begin
        cmd_o.op = skac_pkg::OP_DIVINIT;
        cnt_d    = '0;
        state_d  = S_DIV;
      end
      S_DIV: begin
        cmd_o.op = skac_pkg::OP_DIV;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CW'(skac_pkg::DIV_STEPS - 1)) state_d = S_DSAT;
      end
      S_DSAT: begin
        cmd_o.op = skac_pkg::OP_DSAT;
        state_d  = S_GMUL;
      end
      S_GMUL: begin
        cmd_o.op = skac_pkg::OP_GMUL;
        state_d  = S_GEXP;
      end
      S_GEXP: begin
        cmd_o.op = skac_pkg::OP_GEXP;
        cnt_d    = '0;
        state_d  = S_MANT;
      end
      S_MANT: begin
        cmd_o.op = skac_pkg::OP_MANT;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CW'(skac_pkg::MANT_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = S_OUTC;
        end
      end
      S_OUTC: begin
        cmd_o.op = skac_pkg::OP_OUTC;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CW'(1)) state_d = S_FIN;
      end
      S_FIN: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = skac_pkg::OP_FIN;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- hdl/skac_dpath.sv -----
module skac_dpath #(
  parameter int STREAM_COUNT = skac_pkg::STREAM_COUNT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [skac_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [skac_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                stream_index_i,
  input  logic                                restart_i,
  input  logic [skac_pkg::SAMPLE_BITS-1:0]    sample_left_i,
  input  logic [skac_pkg::SAMPLE_BITS-1:0]    sample_right_i,
  input  skac_pkg::cmd_t                      cmd_i,
  output skac_pkg::sts_t                      sts_o,
  output logic [63:0]                         out_data_o
);

  localparam int SB     = skac_pkg::SAMPLE_BITS;
  localparam int SIDX_W = STREAM_COUNT > 1 ? $clog2(STREAM_COUNT) : 1;
  localparam logic [15:0] ATT_MAX_C = skac_pkg::ATT_MAX;

  // configuration
  logic signed [15:0] thr_q;
  logic [15:0]        slope_q;
  logic [12:0]        knee_q;
  logic signed [13:0] makeup_q;
  logic [23:0]        attack_q;
  logic [23:0]        release_q;
  logic               bypass_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= -16'sd5120;
      slope_q   <= 16'd49152;
      knee_q    <= 13'd1536;
      makeup_q  <= '0;
      attack_q  <= '0;
      release_q <= '0;
      bypass_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        skac_pkg::CFG_THRESHOLD: thr_q     <= cfg_data_i[15:0];
        skac_pkg::CFG_SLOPE:     slope_q   <= cfg_data_i[15:0];
        skac_pkg::CFG_KNEE:      knee_q    <= cfg_data_i[12:0];
        skac_pkg::CFG_MAKEUP:    makeup_q  <= cfg_data_i[13:0];
        skac_pkg::CFG_ATTACK:    attack_q  <= cfg_data_i;
        skac_pkg::CFG_RELEASE:   release_q <= cfg_data_i;
        skac_pkg::CFG_BYPASS:    bypass_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // envelope state, one entry per stream
  logic signed [15:0] env_mem_q [STREAM_COUNT];

  logic [SB-1:0]      smp_q   [2];
  logic [SB-1:0]      mag_q   [2];
  logic               neg_q   [2];
  logic [SB-1:0]      res_q   [2];
  logic [SIDX_W-1:0]  sidx_q;
  logic [31:0]        m_q;
  logic [4:0]         e_q;
  logic [15:0]        frac_q;
  logic signed [63:0] prod_q;
  logic signed [15:0] lvl_q;
  logic signed [15:0] env_q;
  logic signed [17:0] over_q;
  logic [14:0]        red_q;
  logic [26:0]        num_q;
  logic [12:0]        rem_q;
  logic [26:0]        quo_q;
  logic signed [7:0]  n_q;
  logic [15:0]        gfrac_q;
  logic [31:0]        mant_q;
  logic [63:0]        out_q;

  // combinational helpers
  logic [SB-1:0]      mag_l, mag_r, peak;
  logic [SIDX_W-1:0]  sidx_c;
  logic [63:0]        sq_full;
  logic [20:0]        a_w;
  logic [39:0]        att_w;
  logic [15:0]        att_c;
  logic signed [15:0] env_rd;
  logic signed [16:0] diff;
  logic signed [24:0] ca_s;
  logic signed [63:0] t_env;
  logic signed [18:0] two_over;
  logic signed [18:0] knee_s;
  logic [47:0]        asum;
  logic [14:0]        u_w;
  logic [46:0]        nsum;
  logic [13:0]        rem2;
  logic signed [16:0] gdb;
  logic signed [63:0] esum;
  logic signed [63:0] e_w;
  logic [63:0]        mp;
  logic signed [8:0]  sh_s;
  logic [5:0]         sh;
  logic               ch;
  logic [63:0]        y_w;
  logic [63:0]        lim;
  logic [63:0]        yc;

  always_comb begin
    mag_l = sample_left_i[SB-1] ? SB'(~sample_left_i + 1'b1) : sample_left_i;
    mag_r = sample_right_i[SB-1] ? SB'(~sample_right_i + 1'b1) : sample_right_i;
    peak  = (mag_r > mag_l) ? mag_r : mag_l;
    if (32'(stream_index_i) >= 32'(STREAM_COUNT)) sidx_c = SIDX_W'(STREAM_COUNT - 1);
    else sidx_c = SIDX_W'(stream_index_i);

    sq_full = 64'(m_q) * 64'(m_q);
    a_w     = {5'd23 - e_q, 16'd0} - 21'(frac_q);
    att_w   = prod_q[39:0] + 40'd8388608;
    att_c   = (att_w[39:24] > ATT_MAX_C) ? ATT_MAX_C : att_w[39:24];

    env_rd = env_mem_q[sidx_q];
    diff   = 17'(env_rd) - 17'(lvl_q);
    ca_s   = (lvl_q > env_rd) ? signed'({1'b0, attack_q}) : signed'({1'b0, release_q});
    t_env  = (64'(lvl_q) <<< 24) + prod_q + 64'sd8388608;

    two_over = {over_q, 1'b0};
    knee_s   = signed'({6'd0, knee_q});
    asum     = prod_q[47:0] + 48'd32768;
    u_w      = 15'(two_over + knee_s);
    nsum     = prod_q[46:0] + (47'(knee_q) << 18);
    rem2     = {rem_q, num_q[26]};

    gdb  = 17'(makeup_q) - signed'({2'b00, red_q});
    esum = prod_q + 64'sd128;
    e_w  = esum >>> 8;
    mp   = 64'(mant_q) * 64'(skac_pkg::MANT_TAB[cmd_i.cnt[3:0]]) + 64'd536870912;

    // output scale: shift clamped to 1..62
    sh_s = 9'sd30 - 9'(n_q);
    if (sh_s < 9'sd1) sh = 6'd1;
    else if (sh_s > 9'sd62) sh = 6'd62;
    else sh = sh_s[5:0];
    ch  = cmd_i.cnt[0];
    y_w = (64'(mag_q[ch]) * 64'(mant_q) + (64'd1 << (sh - 6'd1))) >> sh;
    lim = neg_q[ch] ? (64'd1 << (SB - 1)) : ((64'd1 << (SB - 1)) - 64'd1);
    yc  = (y_w > lim) ? lim : y_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < STREAM_COUNT; s++) env_mem_q[s] <= skac_pkg::FLOOR_Q88;
    end else begin
      if (cmd_i.op == skac_pkg::OP_LOAD && restart_i) begin
        for (int s = 0; s < STREAM_COUNT; s++) env_mem_q[s] <= skac_pkg::FLOOR_Q88;
      end else if (cmd_i.op == skac_pkg::OP_ENVUPD) begin
        env_mem_q[sidx_q] <= t_env[39:24];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      skac_pkg::OP_LOAD: begin
        smp_q[0] <= sample_left_i;
        smp_q[1] <= sample_right_i;
        mag_q[0] <= mag_l;
        mag_q[1] <= mag_r;
        neg_q[0] <= sample_left_i[SB-1];
        neg_q[1] <= sample_right_i[SB-1];
        sidx_q   <= sidx_c;
        m_q      <= 32'(peak);
        e_q      <= 5'd31;
        frac_q   <= '0;
      end
      skac_pkg::OP_SHIFT: begin
        m_q <= {m_q[30:0], 1'b0};
        e_q <= e_q - 5'd1;
      end
      skac_pkg::OP_SQR: begin
        if (sq_full[63]) begin
          frac_q[4'd15 - cmd_i.cnt[3:0]] <= 1'b1;
          m_q <= sq_full[63:32];
        end else begin
          m_q <= sq_full[62:31];
        end
      end
      skac_pkg::OP_ATT:   prod_q <= 64'(a_w) * 64'(skac_pkg::DB_PER_LOG2_Q16);
      skac_pkg::OP_LVL: begin
        if (17'(att_c) > skac_pkg::NEG_FLOOR) lvl_q <= skac_pkg::FLOOR_Q88;
        else lvl_q <= 16'(-signed'({1'b0, att_c}));
      end
      skac_pkg::OP_FLOOR:  lvl_q <= skac_pkg::FLOOR_Q88;
      skac_pkg::OP_ENVMUL: prod_q <= 64'(diff) * 64'(ca_s);
      skac_pkg::OP_ENVUPD: env_q <= t_env[39:24];
      skac_pkg::OP_OVER:   over_q <= 18'(env_q) - 18'(thr_q);
      skac_pkg::OP_RZERO:  red_q <= '0;
      skac_pkg::OP_AMUL:   prod_q <= 64'(over_q[16:0]) * 64'(slope_q);
      skac_pkg::OP_ASAT: begin
        red_q <= (asum[47:16] > 32'(skac_pkg::RED_MAX)) ? skac_pkg::RED_MAX
                                                        : asum[30:16];
      end
      skac_pkg::OP_USQ:    prod_q <= 64'(u_w) * 64'(u_w);
      skac_pkg::OP_USLOPE: prod_q <= 64'(prod_q[29:0]) * 64'(slope_q);
      skac_pkg::OP_DIVINIT: begin
        num_q <= nsum[45:19];
        rem_q <= '0;
        quo_q <= '0;
      end
      skac_pkg::OP_DIV: begin
        num_q <= {num_q[25:0], 1'b0};
        if (rem2 >= {1'b0, knee_q}) begin
          rem_q <= 13'(rem2 - {1'b0, knee_q});
          quo_q <= {quo_q[25:0], 1'b1};
        end else begin
          rem_q <= rem2[12:0];
          quo_q <= {quo_q[25:0], 1'b0};
        end
      end
      skac_pkg::OP_DSAT: begin
        red_q <= (quo_q > 27'(skac_pkg::RED_MAX)) ? skac_pkg::RED_MAX : quo_q[14:0];
      end
      skac_pkg::OP_GMUL: prod_q <= 64'(gdb) * 64'(skac_pkg::LOG2_PER_DB_Q16);
      skac_pkg::OP_GEXP: begin
        n_q     <= e_w[23:16];
        gfrac_q <= e_w[15:0];
        mant_q  <= 32'd1 << 30;
      end
      skac_pkg::OP_MANT: begin
        if (gfrac_q[4'd15 - cmd_i.cnt[3:0]]) mant_q <= mp[61:30];
      end
      skac_pkg::OP_OUTC: begin
        res_q[ch] <= neg_q[ch] ? SB'(~yc[SB-1:0] + 1'b1) : yc[SB-1:0];
      end
      skac_pkg::OP_BYPASS: begin
        res_q[0] <= smp_q[0];
        res_q[1] <= smp_q[1];
        red_q    <= '0;
      end
      skac_pkg::OP_FIN: out_q <= {1'b0, red_q, res_q[1], res_q[0]};
      default: ;
    endcase
  end

  assign sts_o.bypass    = bypass_q;
  assign sts_o.peak_zero = (m_q == 32'd0);
  assign sts_o.norm_done = m_q[31];
  assign sts_o.below     = two_over < -knee_s;
  assign sts_o.above     = two_over > knee_s;
  assign sts_o.knee_zero = (knee_q == 13'd0);
  assign out_data_o      = out_q;

endmodule

// ----- hdl/soft_knee_audio_compressor_top.sv -----
// soft knee audio compressor, one stereo frame per transaction
//
// s_axis carries a frame: tdata holds the two samples, tuser the stream slot
// and the restart flag. m_axis returns the scaled samples and the applied
// gain reduction. cfg writes one register per transaction (index, data) and
// is always ready; write it only while the block is idle.
//
// one frame is processed at a time by a sequencer over a shared datapath.
// in bypass the samples pass straight to the output register. otherwise the
// number of normalize shifts is 31 minus the bit position of the peak magnitude,
// and the knee divider runs only inside the knee. a silent frame skips the
// shifts, the 16 log squaring steps and the level conversion. the longest frame
// runs through the normalize shifter, the log squaring loop, the 27 step knee
// divider and the 16 step gain mantissa loop; the next frame can be taken in
// the same cycle that output valid rises.
//
// reset puts the config registers at their defaults and every stream envelope at the
// silence floor. the next frame is accepted while a result waits in the output
// register; a stalled receiver holds the result and the block stops before
// delivering the following one.
module soft_knee_audio_compressor_top #(
  parameter int STREAM_COUNT = skac_pkg::STREAM_COUNT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // sample_left, sample_right
  input  logic [1:0]  s_axis_tuser,   // stream_index, restart
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // out_left, out_right, reduction_level, pad
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [skac_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [skac_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  skac_pkg::cmd_t cmd;
  skac_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  skac_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  skac_dpath #(
    .STREAM_COUNT (STREAM_COUNT)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .stream_index_i (s_axis_tuser[0]),
    .restart_i      (s_axis_tuser[1]),
    .sample_left_i  (s_axis_tdata[23:0]),
    .sample_right_i (s_axis_tdata[47:24]),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_data_o     (m_axis_tdata)
  );

endmodule

// ----- hdl/skac_checker.sv -----
`include "soft_knee_audio_compressor_top_defines.svh"

module skac_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  `SKAC_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
  `SKAC_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second frame taken while busy")
  `SKAC_ASSERT_IMP(a_pad_zero, m_axis_tvalid, !m_axis_tdata[63], "output pad bit set")

endmodule

bind soft_knee_audio_compressor_top skac_checker u_skac_checker (.*);

// ----- verif/soft_knee_audio_compressor_top_tb.sv -----
`timescale 1ns / 1ps

module soft_knee_audio_compressor_top_tb;

  typedef struct packed {
    logic        restart;
    logic        stream;
    logic [23:0] right;
    logic [23:0] left;
  } frame_t;

  typedef struct packed {
    logic [14:0] reduction;
    logic [23:0] right;
    logic [23:0] left;
  } scaled_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [skac_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [skac_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  soft_knee_audio_compressor_top dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #10 clk_i = ~clk_i;

  // predictor copy of the register file and envelopes
  logic signed [15:0] thr_q;
  logic [15:0]        slope_q;
  logic [12:0]        knee_q;
  logic signed [13:0] makeup_q;
  logic [23:0]        attack_q;
  logic [23:0]        release_q;
  logic               bypass_q;
  int                 env_db [2];
  longint unsigned    pow_tab [16];

  frame_t  pending_frames [$];
  scaled_t expected_out [$];
  int      mismatches = 0;
  int      out_count = 0;
  bit      pressure_done = 1'b0;
  int      quiet_cycles = 0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic int peak_to_db(longint unsigned p);
    int              e;
    longint unsigned m, frac, a, att;
    if (p == 0) return int'(skac_pkg::FLOOR_Q88);
    e = 0;
    while ((p >> (e + 1)) != 0 && e < 62) e++;
    m = p << (31 - e);
    frac = 0;
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 31;
      if (m >= (64'd1 << 32)) begin
        frac |= 64'd1 << (15 - i);
        m >>= 1;
      end
    end
    a = longint'(23 - e) * 65536 - frac;
    att = (a * 394566 + (64'd1 << 23)) >> 24;
    if (att > 40000) att = 40000;
    return (-int'(att) < int'(skac_pkg::FLOOR_Q88)) ? int'(skac_pkg::FLOOR_Q88)
                                                     : -int'(att);
  endfunction

  function automatic int knee_reduction(int env);
    longint          over, knee;
    longint unsigned r, u, den;
    over = longint'(env) - longint'(thr_q);
    knee = longint'(knee_q);
    if (2 * over < -knee) return 0;
    if (2 * over > knee) begin
      r = (longint'(over) * longint'(slope_q) + 32768) >> 16;
    end else begin
      if (knee == 0) return 0;
      u = 2 * over + knee;
      den = knee * 8 * 65536;
      r = (u * u * slope_q + den / 2) / den;
    end
    return (r > 32767) ? 32767 : int'(r);
  endfunction

  function automatic scaled_t compress_frame(frame_t f);
    scaled_t         res;
    longint unsigned mag [2];
    bit              neg [2];
    longint unsigned peak, ca, eq, frac, mant, y, lim;
    longint          t, ue;
    int              lvl, env, red, gdb, n, sh, s;
    logic [23:0]     smp [2];
    if (f.restart) begin
      env_db[0] = int'(skac_pkg::FLOOR_Q88);
      env_db[1] = int'(skac_pkg::FLOOR_Q88);
    end
    if (bypass_q) begin
      res.left = f.left;
      res.right = f.right;
      res.reduction = '0;
      return res;
    end
    s = f.stream;
    smp[0] = f.left;
    smp[1] = f.right;
    peak = 0;
    for (int c = 0; c < 2; c++) begin
      neg[c] = smp[c][23];
      mag[c] = neg[c] ? (64'd1 << 24) - smp[c] : smp[c];
      if (mag[c] > peak) peak = mag[c];
    end
    lvl = peak_to_db(peak);
    env = env_db[s];
    ca = (lvl > env) ? attack_q : release_q;
    t = longint'(env) * longint'(ca) + longint'(lvl) * longint'((64'd1 << 24) - ca);
    env = int'(((t + (64'sd1 << 40) + (64'sd1 << 23)) >>> 24) - 65536);
    env_db[s] = env;
    red = knee_reduction(env);
    gdb = int'(makeup_q) - red;
    ue = longint'(gdb) * 10885 + (64'sd1 << 32);
    eq = (longint'(ue) + 128) >> 8;
    n = int'(eq >> 16) - 256;
    frac = eq & 64'hFFFF;
    mant = 64'd1 << 30;
    for (int k = 0; k < 16; k++)
      if (frac[15 - k]) mant = (mant * pow_tab[k] + (64'd1 << 29)) >> 30;
    sh = 30 - n;
    if (sh < 1) sh = 1;
    if (sh > 62) sh = 62;
    for (int c = 0; c < 2; c++) begin
      y = (mag[c] * mant + (64'd1 << (sh - 1))) >> sh;
      lim = neg[c] ? (64'd1 << 23) : (64'd1 << 23) - 1;
      if (y > lim) y = lim;
      smp[c] = neg[c] ? 24'((64'd1 << 24) - y) : 24'(y);
    end
    res.left = smp[0];
    res.right = smp[1];
    res.reduction = 15'(red);
    return res;
  endfunction

  // sender side
  bit in_busy = 1'b0;
  int in_gap = 0;
  always @(posedge clk_i) begin
    frame_t f;
    bit     busy;
    busy = in_busy;
    if (in_busy && s_axis_tready) begin
      f.left = s_axis_tdata[23:0];
      f.right = s_axis_tdata[47:24];
      f.stream = s_axis_tuser[0];
      f.restart = s_axis_tuser[1];
      expected_out.push_back(compress_frame(f));
      busy = 1'b0;
    end
    if (rst_ni && !busy) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
      end else if (pending_frames.size() > 0) begin
        f = pending_frames.pop_front();
        s_axis_tdata <= {f.right, f.left};
        s_axis_tuser <= {f.restart, f.stream};
        busy = 1'b1;
        in_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      end
    end
    in_busy <= busy;
    s_axis_tvalid <= busy;
  end

  // receiver side
  int out_stall = 0;
  always @(posedge clk_i) begin
    scaled_t got, want;
    bit      rdy;
    rdy = m_axis_tready;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[62:0];
      out_count++;
      if (expected_out.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction %h", got);
      end else begin
        want = expected_out.pop_front();
        if (got.left !== want.left || got.right !== want.right ||
            got.reduction !== want.reduction) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: left %h/%h right %h/%h reduction %0d/%0d (exp/got)",
                     out_count, want.left, got.left, want.right, got.right,
                     want.reduction, got.reduction);
        end
      end
      rdy = 1'b0;
      if (out_count == 120 && !pressure_done) begin
        pressure_done = 1'b1;
        out_stall <= 400;
      end else begin
        out_stall <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      end
    end else if (rst_ni && !rdy) begin
      if (out_stall > 0) out_stall <= out_stall - 1;
      else rdy = 1'b1;
    end
    m_axis_tready <= rdy;
  end

  // watchdog on handshake activity
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(logic [skac_pkg::CFG_IDX_W-1:0] idx, int value);
    cfg_index_i <= idx;
    cfg_data_i <= skac_pkg::CFG_DATA_W'(value);
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      skac_pkg::CFG_THRESHOLD: thr_q = 16'(value);
      skac_pkg::CFG_SLOPE:     slope_q = 16'(value);
      skac_pkg::CFG_KNEE:      knee_q = 13'(value);
      skac_pkg::CFG_MAKEUP:    makeup_q = 14'(value);
      skac_pkg::CFG_ATTACK:    attack_q = 24'(value);
      skac_pkg::CFG_RELEASE:   release_q = 24'(value);
      skac_pkg::CFG_BYPASS:    bypass_q = value[0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic setup(int thr, int slope, int knee, int mk, int att, int rel, int byp);
    write_reg(skac_pkg::CFG_THRESHOLD, thr);
    write_reg(skac_pkg::CFG_SLOPE, slope);
    write_reg(skac_pkg::CFG_KNEE, knee);
    write_reg(skac_pkg::CFG_MAKEUP, mk);
    write_reg(skac_pkg::CFG_ATTACK, att);
    write_reg(skac_pkg::CFG_RELEASE, rel);
    write_reg(skac_pkg::CFG_BYPASS, byp);
  endtask

  function automatic logic [23:0] pick_sample();
    logic signed [23:0] v;
    case ($urandom_range(0, 11))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return 24'h000000;
      default: begin
        v = 24'($urandom);
        return v >>> $urandom_range(0, 23);
      end
    endcase
  endfunction

  task automatic add_frame(logic [23:0] l, logic [23:0] r, bit s, bit rs);
    frame_t f;
    f.left = l;
    f.right = r;
    f.stream = s;
    f.restart = rs;
    pending_frames.push_back(f);
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (pending_frames.size() > 0 || in_busy || s_axis_tvalid ||
           expected_out.size() > 0);
  endtask

  task automatic random_frames(int count);
    repeat (count)
      add_frame(pick_sample(), pick_sample(), $urandom_range(0, 1),
                $urandom_range(0, 24) == 0);
  endtask

  initial begin
    thr_q = -16'sd5120;
    slope_q = 16'd49152;
    knee_q = 13'd1536;
    makeup_q = '0;
    attack_q = '0;
    release_q = '0;
    bypass_q = 1'b0;
    env_db[0] = int'(skac_pkg::FLOOR_Q88);
    env_db[1] = int'(skac_pkg::FLOOR_Q88);
    pow_tab[0] = int_sqrt(64'd1 << 61);
    for (int k = 1; k < 16; k++) pow_tab[k] = int_sqrt(pow_tab[k - 1] << 30);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed frames on reset settings: extremes, silence, restart, both streams
    add_frame(24'h000000, 24'h000000, 1'b0, 1'b0);
    add_frame(24'h7FFFFF, 24'h000001, 1'b0, 1'b0);
    add_frame(24'h800000, 24'h7FFFFF, 1'b1, 1'b0);
    add_frame(24'hFFFFFF, 24'h800000, 1'b1, 1'b0);
    add_frame(24'h000001, 24'hFFFFFF, 1'b0, 1'b1);
    add_frame(24'h400000, 24'hC00000, 1'b1, 1'b0);
    add_frame(24'h0A0000, 24'h050000, 1'b0, 1'b0);
    add_frame(24'h000000, 24'h000000, 1'b1, 1'b1);
    add_frame(24'h7FFFFF, 24'h7FFFFF, 1'b0, 1'b0);
    add_frame(24'h000100, 24'hFFFF00, 1'b1, 1'b0);
    drain();

    // hard knee, steepest slope, max makeup, instant envelope
    setup(0, 65535, 0, 6144, 0, 0, 0);
    random_frames(100);
    drain();
    // lowest threshold, widest knee, min makeup, frozen envelope
    setup(-24576, 0, 6144, -6144, 24'hFFFFFF, 24'hFFFFFF, 0);
    random_frames(60);
    drain();
    // bypass with restarts mixed in
    setup(-3000, 30000, 2000, 1000, 24'h800000, 24'hF00000, 1);
    random_frames(60);
    drain();
    for (int p = 0; p < 5; p++) begin
      setup(-$urandom_range(0, 24576), $urandom_range(0, 65535),
            ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6144),
            $urandom_range(0, 12288) - 6144,
            ($urandom_range(0, 1) == 1) ? $urandom_range(24'hE00000, 24'hFFFFFF)
                                        : $urandom_range(0, 24'hFFFFFF),
            ($urandom_range(0, 1) == 1) ? $urandom_range(24'hF00000, 24'hFFFFFF)
                                        : $urandom_range(0, 24'hFFFFFF),
            0);
      random_frames(105);
      drain();
    end

    repeat (200) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/skac_pkg.sv
hdl/skac_ctrl.sv
hdl/skac_dpath.sv
hdl/soft_knee_audio_compressor_top.sv
hdl/skac_checker.sv
verif/soft_knee_audio_compressor_top_tb.sv
